FILE: rtl/binary_collision_pair_scheduler_top_macros.svh
// Assertion macros for the binary collision pair scheduler.
// Expects clk and rst_n in the scope of the including module.
`ifndef BINARY_COLLISION_PAIR_SCHEDULER_TOP_MACROS_SVH
`define BINARY_COLLISION_PAIR_SCHEDULER_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset
`define BCPS_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bcps: same-cycle check failed");

// Next-cycle implication, checked outside reset
`define BCPS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bcps: next-cycle check failed");

`endif

FILE: rtl/bcps_pkg.sv
// Shared types and constants of the binary collision pair scheduler.
// No dependencies; imported by every module of the block.
`default_nettype none

package bcps_pkg;

    localparam int CNT_W        = 5;   // particle count, 0..16
    localparam int IDX_W        = 4;   // particle index
    localparam int NP_W         = 4;   // like-species pairs per species, up to 9
    localparam int DIV_STEP_W   = 3;   // divider step counter
    localparam int MAX_PER_CELL = 16;
    localparam int S_TDATA_W    = 16;
    localparam int M_TDATA_W    = 8;
    localparam int M_TUSER_W    = 2;

    typedef logic [CNT_W-1:0] cnt_t;
    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [NP_W-1:0]  np_t;

    typedef enum logic [1:0] {
        KIND_ION = 2'd0,
        KIND_EL  = 2'd1,
        KIND_EI  = 2'd2
    } kind_t;

    typedef struct packed {
        logic  valid;
        kind_t kind;
        idx_t  first;
        idx_t  second;
        logic  last;
    } pair_t;

    typedef struct packed {
        logic done;
        cnt_t quo;
        cnt_t rem;
    } div_res_t;

endpackage

`default_nettype wire

FILE: rtl/bcps_div.sv
// Restoring divider, one quotient bit per cycle, for the count split.
// Depends on bcps_pkg.
`default_nettype none

module bcps_div (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  bcps_pkg::cnt_t     dividend,
    input  bcps_pkg::cnt_t     divisor,
    output bcps_pkg::div_res_t res
);
    import bcps_pkg::*;

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [DIV_STEP_W-1:0] step_reg, step_next;
    cnt_t                  rem_reg, rem_next;
    cnt_t                  quo_reg, quo_next;
    cnt_t                  dvs_reg, dvs_next;

    logic [CNT_W:0] trial;
    logic [CNT_W:0] diff;
    logic           fits;

    assign trial = {rem_reg, quo_reg[CNT_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign fits  = (trial >= {1'b0, dvs_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            // shift in the next dividend bit, subtract where it fits
            rem_next  = fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
            quo_next  = {quo_reg[CNT_W-2:0], fits};
            step_next = step_reg + 1'b1;
            if (step_reg == DIV_STEP_W'(CNT_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign res.done = done_reg;
    assign res.quo  = quo_reg;
    assign res.rem  = rem_reg;

endmodule

`default_nettype wire

FILE: rtl/bcps_gen.sv
// Pair sequencer: walks ion-ion, electron-electron and electron-ion phases.
// Depends on bcps_pkg and bcps_div.
`default_nettype none

module bcps_gen (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  bcps_pkg::cnt_t ni,
    input  bcps_pkg::cnt_t ne,
    input  logic           adv,
    output bcps_pkg::pair_t pair,
    output logic           busy
);
    import bcps_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_ION,
        ST_EL,
        ST_EI
    } state_t;

    state_t   state_reg, state_next;
    cnt_t     ni_reg, ni_next;
    cnt_t     ne_reg, ne_next;
    np_t      np_ion_reg, np_ion_next;
    np_t      np_el_reg, np_el_next;
    np_t      j_reg, j_next;
    cnt_t     big_reg, big_next;
    logic     big_ion_reg, big_ion_next;
    cnt_t     q_reg, q_next;
    cnt_t     r_reg, r_next;
    cnt_t     s_reg, s_next;
    cnt_t     grp_reg, grp_next;
    cnt_t     k_reg, k_next;

    div_res_t div_res;
    logic     ei_en;
    logic     phase_end;
    cnt_t     per;
    cnt_t     lp_first, lp_second;
    cnt_t     lp_n;

    function automatic np_t like_np(input cnt_t n);
        cnt_t t;
        t = n + cnt_t'(3);
        if (n < cnt_t'(2))
            return '0;
        else if (!n[0])
            return n[NP_W:1];
        else
            return t[NP_W:1];
    endfunction

    bcps_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .dividend ((ni > ne) ? ni : ne),
        .divisor  ((ni > ne) ? ne : ni),
        .res      (div_res)
    );

    assign ei_en = (ni_reg != '0) && (ne_reg != '0);
    assign per   = (s_reg < r_reg) ? (q_reg + 1'b1) : q_reg;
    assign lp_n  = (state_reg == ST_EL) ? ne_reg : ni_reg;

    // like-species indices: triangle first for odd counts, then neighbours
    always_comb
    begin
        lp_first  = {j_reg, 1'b0};
        lp_second = {j_reg, 1'b1};
        if (lp_n[0])
        begin
            unique case (j_reg)
                np_t'(0):
                begin
                    lp_first  = cnt_t'(0);
                    lp_second = cnt_t'(1);
                end
                np_t'(1):
                begin
                    lp_first  = cnt_t'(1);
                    lp_second = cnt_t'(2);
                end
                np_t'(2):
                begin
                    lp_first  = cnt_t'(2);
                    lp_second = cnt_t'(0);
                end
                default:
                begin
                    lp_first  = {j_reg, 1'b0} - cnt_t'(3);
                    lp_second = {j_reg, 1'b0} - cnt_t'(2);
                end
            endcase
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        ni_next      = ni_reg;
        ne_next      = ne_reg;
        np_ion_next  = np_ion_reg;
        np_el_next   = np_el_reg;
        j_next       = j_reg;
        big_next     = big_reg;
        big_ion_next = big_ion_reg;
        q_next       = q_reg;
        r_next       = r_reg;
        s_next       = s_reg;
        grp_next     = grp_reg;
        k_next       = k_reg;
        phase_end    = 1'b0;

        pair.valid  = 1'b0;
        pair.kind   = KIND_ION;
        pair.first  = lp_first[IDX_W-1:0];
        pair.second = lp_second[IDX_W-1:0];
        pair.last   = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    ni_next      = ni;
                    ne_next      = ne;
                    np_ion_next  = like_np(ni);
                    np_el_next   = like_np(ne);
                    big_next     = (ni > ne) ? ni : ne;
                    big_ion_next = (ni > ne);
                    state_next   = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_res.done)
                begin
                    q_next   = div_res.quo;
                    r_next   = div_res.rem;
                    j_next   = '0;
                    s_next   = '0;
                    grp_next = '0;
                    k_next   = '0;
                    priority if (np_ion_reg != '0)
                        state_next = ST_ION;
                    else if (np_el_reg != '0)
                        state_next = ST_EL;
                    else if (ei_en)
                        state_next = ST_EI;
                    else
                        state_next = ST_IDLE;
                end
            end
            ST_ION:
            begin
                phase_end  = (j_reg == np_ion_reg - 1'b1);
                pair.valid = 1'b1;
                pair.kind  = KIND_ION;
                pair.last  = phase_end && (np_el_reg == '0) && !ei_en;
                if (adv)
                begin
                    j_next = j_reg + 1'b1;
                    if (phase_end)
                    begin
                        j_next = '0;
                        priority if (np_el_reg != '0)
                            state_next = ST_EL;
                        else if (ei_en)
                            state_next = ST_EI;
                        else
                            state_next = ST_IDLE;
                    end
                end
            end
            ST_EL:
            begin
                phase_end  = (j_reg == np_el_reg - 1'b1);
                pair.valid = 1'b1;
                pair.kind  = KIND_EL;
                pair.last  = phase_end && !ei_en;
                if (adv)
                begin
                    j_next = j_reg + 1'b1;
                    if (phase_end)
                        state_next = ei_en ? ST_EI : ST_IDLE;
                end
            end
            ST_EI:
            begin
                // one pair per member of the larger species; s serves per partners
                phase_end   = (k_reg == big_reg - 1'b1);
                pair.valid  = 1'b1;
                pair.kind   = KIND_EI;
                pair.first  = big_ion_reg ? s_reg[IDX_W-1:0] : k_reg[IDX_W-1:0];
                pair.second = big_ion_reg ? k_reg[IDX_W-1:0] : s_reg[IDX_W-1:0];
                pair.last   = phase_end;
                if (adv)
                begin
                    k_next = k_reg + 1'b1;
                    if (grp_reg == per - 1'b1)
                    begin
                        grp_next = '0;
                        s_next   = s_reg + 1'b1;
                    end
                    else
                        grp_next = grp_reg + 1'b1;
                    if (phase_end)
                        state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        ni_reg      <= ni_next;
        ne_reg      <= ne_next;
        np_ion_reg  <= np_ion_next;
        np_el_reg   <= np_el_next;
        j_reg       <= j_next;
        big_reg     <= big_next;
        big_ion_reg <= big_ion_next;
        q_reg       <= q_next;
        r_reg       <= r_next;
        s_reg       <= s_next;
        grp_reg     <= grp_next;
        k_reg       <= k_next;
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

`default_nettype wire

FILE: rtl/binary_collision_pair_scheduler_top.sv
// Channel   Dir  Ports                        Contents (lowest bit first)
// s_axis    in   s_tvalid s_tready s_tdata    n_ions[4:0], n_electrons[9:5]
// m_axis    out  m_tvalid m_tready m_tdata    first_index[3:0], second_index[7:4]
//                m_tuser m_tlast              pair_kind in tuser, last_pair as tlast
//
// For a cell with P pairs (P in 0..33), the 5-bit restoring divider needs five
// steps before any pair leaves, then the sequencer issues one pair a cycle
// unless m_tready stalls it. s_tready is low until the sequencer is idle again.
// A stall on m_tready holds the sequencer; the last pair may still wait in the
// output register while the next cell is accepted.
// Reset (rst_n, asynchronous, active low) clears the sequencer and output valid.
//
// Top level of the binary collision pair scheduler.
// Depends on bcps_pkg, bcps_gen, bcps_div and the assertion macro header.
`default_nettype none

`include "binary_collision_pair_scheduler_top_macros.svh"

module binary_collision_pair_scheduler_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [bcps_pkg::S_TDATA_W-1:0] s_tdata,  // n_ions, n_electrons, zero fill
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [bcps_pkg::M_TDATA_W-1:0] m_tdata,  // first_index, second_index
    output logic [bcps_pkg::M_TUSER_W-1:0] m_tuser,  // pair_kind
    output logic                           m_tlast   // last_pair
);
    import bcps_pkg::*;

    logic  gen_busy;
    logic  adv;
    logic  start;
    cnt_t  ni_sat;
    cnt_t  ne_sat;
    pair_t gen_pair;

    logic  out_valid_reg, out_valid_next;
    pair_t out_pair_reg, out_pair_next;

    // clamp a count above the cell limit to the limit
    function automatic cnt_t sat_count(input cnt_t n);
        if (n > cnt_t'(MAX_PER_CELL))
            return cnt_t'(MAX_PER_CELL);
        else
            return n;
    endfunction

    assign ni_sat   = sat_count(s_tdata[CNT_W-1:0]);
    assign ne_sat   = sat_count(s_tdata[2*CNT_W-1:CNT_W]);
    assign s_tready = !gen_busy;
    assign start    = s_tvalid && s_tready;

    // advance the sequencer whenever the output register is free or drains
    assign adv = !out_valid_reg || m_tready;

    bcps_gen u_gen (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .ni    (ni_sat),
        .ne    (ne_sat),
        .adv   (adv),
        .pair  (gen_pair),
        .busy  (gen_busy)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_pair_next  = out_pair_reg;
        if (adv)
        begin
            out_valid_next = gen_pair.valid;
            if (gen_pair.valid)
                out_pair_next = gen_pair;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    // hold the payload while stalled
    always_ff @(posedge clk)
    begin
        out_pair_reg <= out_pair_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_pair_reg.second, out_pair_reg.first};
    assign m_tuser  = out_pair_reg.kind;
    assign m_tlast  = out_pair_reg.last;

    // a cell once taken keeps the input closed until its pairs are issued
    `BCPS_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
    // once the final pair is issued the sequencer has nothing more for this cell
    `BCPS_ASSERT_NEXT(a_last_ends_cell, gen_pair.valid && gen_pair.last && adv,
                      !gen_pair.valid)
    // a like-species pair never collides a particle with itself
    `BCPS_ASSERT_IMPLY(a_no_self_pair, m_tvalid && (m_tuser != KIND_EI),
                       m_tdata[IDX_W-1:0] != m_tdata[2*IDX_W-1:IDX_W])

endmodule

`default_nettype wire
